/* rtl/gsoa_pkg.sv */
// Package for the gated steering offset average block.
// Holds widths, register indexes, reset values and the CORDIC arctangent table.
package gsoa_pkg;
	localparam int MAX_WINDOW_DEF = 1024;
	localparam int ATAN_ITER_DEF = 16;
	localparam int TABLE_LEN = 24;
	localparam int ZW = 32;
	localparam int XW = 32;
	localparam int SUMW = 27;
	localparam int DEVW = 17;

	localparam logic [2:0] REG_WINDOW = 3'd0;
	localparam logic [2:0] REG_SPEED_TH = 3'd1;
	localparam logic [2:0] REG_ANGLE_TH = 3'd2;
	localparam logic [2:0] REG_LIMIT = 3'd3;
	localparam logic [2:0] REG_WHEELBASE = 3'd4;

	localparam logic [10:0] WINDOW_RST = 11'd1000;
	localparam logic [14:0] SPEED_TH_RST = 15'd2048;
	localparam logic [14:0] ANGLE_TH_RST = 15'd410;
	localparam logic [14:0] LIMIT_RST = 15'd164;
	localparam logic [11:0] WHEELBASE_RST = 12'd768;

	localparam logic signed [ZW-1:0] HALF_PI_Z = 32'sd421657428;

	typedef struct packed {
		logic start;
		logic commit;
		logic div_start;
	} cmd_t;

	typedef struct packed {
		logic cordic_done;
		logic div_done;
	} stat_t;

	function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				5'd0: r = 32'sd210828714;
				5'd1: r = 32'sd124459457;
				5'd2: r = 32'sd65760959;
				5'd3: r = 32'sd33381290;
				5'd4: r = 32'sd16755422;
				5'd5: r = 32'sd8385879;
				5'd6: r = 32'sd4193963;
				5'd7: r = 32'sd2097109;
				5'd8: r = 32'sd1048571;
				5'd9: r = 32'sd524287;
				5'd10: r = 32'sd262144;
				5'd11: r = 32'sd131072;
				5'd12: r = 32'sd65536;
				5'd13: r = 32'sd32768;
				5'd14: r = 32'sd16384;
				5'd15: r = 32'sd8192;
				5'd16: r = 32'sd4096;
				5'd17: r = 32'sd2048;
				5'd18: r = 32'sd1024;
				5'd19: r = 32'sd512;
				5'd20: r = 32'sd256;
				5'd21: r = 32'sd128;
				5'd22: r = 32'sd64;
				5'd23: r = 32'sd32;
				default: r = '0;
			endcase
			return r;
		end
	endfunction
endpackage

/* rtl/gsoa_datapath.sv */
// Datapath: gate, CORDIC atan2, deviation ring memory, running sum and divider.
// Depends on gsoa_pkg; driven by gsoa_ctrl through cmd_t, reports back through stat_t.
module gsoa_datapath #(
	parameter int MAX_WINDOW = gsoa_pkg::MAX_WINDOW_DEF,
	parameter int ATAN_ITERATIONS = gsoa_pkg::ATAN_ITER_DEF,
	localparam int AW = $clog2(MAX_WINDOW),
	localparam int CW = $clog2(MAX_WINDOW + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic signed [15:0] speed,
	input logic signed [15:0] yaw_rate,
	input logic signed [15:0] wheel_angle,
	input logic [10:0] window_length,
	input logic [14:0] speed_threshold,
	input logic [14:0] angle_threshold,
	input logic [14:0] clamp_limit,
	input logic [11:0] wheelbase_length,
	input gsoa_pkg::cmd_t cmd,
	output gsoa_pkg::stat_t stat,
	output logic taken,
	output logic signed [15:0] offset_estimate,
	output logic estimate_valid
);
	localparam int ITERS = (ATAN_ITERATIONS < gsoa_pkg::TABLE_LEN) ?
		ATAN_ITERATIONS : gsoa_pkg::TABLE_LEN;
	localparam int NW = gsoa_pkg::SUMW;
	localparam int OW = CW + 1;
	localparam logic [CW-1:0] MAXW = CW'(MAX_WINDOW);

	logic signed [15:0] spd_q, yaw_q, ang_q;
	logic signed [gsoa_pkg::XW-1:0] x_q, y_q;
	logic signed [gsoa_pkg::ZW-1:0] z_q;
	logic [4:0] it_q;
	logic busy_q;
	logic taken_c;
	logic [16:0] abs_spd, abs_ang;

	logic signed [gsoa_pkg::DEVW-1:0] ring_q [MAX_WINDOW];
	logic signed [gsoa_pkg::DEVW-1:0] old_q, dev_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic signed [NW-1:0] sum_q;
	logic signed [gsoa_pkg::DEVW-1:0] mean_q;
	logic [CW-1:0] win;
	logic full;
	logic [OW-1:0] old_sum;
	logic [AW-1:0] old_addr;

	// divider
	logic [NW-1:0] dnum_q, drem_q;
	logic [4:0] dcnt_q;
	logic dneg_q, dbusy_q;
	logic [NW:0] dtrial;

	assign abs_spd = speed[15] ? 17'(-$signed({speed[15], speed})) : {1'b0, speed};
	assign abs_ang = wheel_angle[15] ? 17'(-$signed({wheel_angle[15], wheel_angle}))
		: {1'b0, wheel_angle};
	assign taken_c = (abs_spd > {2'b0, speed_threshold}) &&
		(abs_ang < {2'b0, angle_threshold});

	always_comb begin
		if (window_length == 11'd0)
			win = CW'(1);
		else if (32'(window_length) > 32'(MAX_WINDOW))
			win = MAXW;
		else
			win = CW'(window_length);
	end
	assign full = count_q >= win;

	// oldest stored slot, head - count modulo the ring size
	assign old_sum = OW'(head_q) + OW'(MAX_WINDOW) - OW'(count_q);
	assign old_addr = (old_sum >= OW'(MAX_WINDOW)) ? AW'(old_sum - OW'(MAX_WINDOW))
		: AW'(old_sum);

	logic signed [gsoa_pkg::XW-1:0] xs, ys, x0, y0;
	logic signed [gsoa_pkg::ZW-1:0] z0;
	logic signed [gsoa_pkg::ZW-1:0] zr;
	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign zr = (z_q + 32'sd16384) >>> 15;

	always_comb begin
		logic signed [gsoa_pkg::XW-1:0] xi, yi;
		xi = gsoa_pkg::XW'(spd_q) <<< 12;
		yi = gsoa_pkg::XW'(yaw_q) * $signed({1'b0, wheelbase_length});
		x0 = xi;
		y0 = yi;
		z0 = '0;
		if (xi < 0) begin
			if (yi >= 0) begin
				x0 = yi; y0 = -xi; z0 = gsoa_pkg::HALF_PI_Z;
			end else begin
				x0 = -yi; y0 = xi; z0 = -gsoa_pkg::HALF_PI_Z;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			it_q <= '0;
			taken <= 1'b0;
		end else if (load) begin
			taken <= taken_c;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			it_q <= '0;
		end else if (busy_q) begin
			if (it_q == 5'(ITERS - 1))
				busy_q <= 1'b0;
			it_q <= it_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			spd_q <= speed;
			yaw_q <= yaw_rate;
			ang_q <= wheel_angle;
		end else if (cmd.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
			old_q <= ring_q[old_addr];
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys; y_q <= y_q - xs;
				z_q <= z_q + gsoa_pkg::atan_entry(it_q);
			end else begin
				x_q <= x_q - ys; y_q <= y_q + xs;
				z_q <= z_q - gsoa_pkg::atan_entry(it_q);
			end
		end
	end

	assign dev_q = gsoa_pkg::DEVW'(ang_q) - gsoa_pkg::DEVW'(zr);

	always_ff @(posedge clk) begin
		if (cmd.commit)
			ring_q[head_q] <= dev_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			sum_q <= '0;
		end else if (cmd.commit) begin
			head_q <= (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
			if (full)
				sum_q <= sum_q - NW'(old_q) + NW'(dev_q);
			else begin
				sum_q <= sum_q + NW'(dev_q);
				count_q <= count_q + CW'(1);
			end
		end
	end

	assign dtrial = {drem_q, dnum_q[NW-1]} - {{(NW + 1 - CW){1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dcnt_q <= '0;
			mean_q <= '0;
		end else if (cmd.div_start) begin
			dbusy_q <= 1'b1;
			dcnt_q <= '0;
		end else if (dbusy_q) begin
			dcnt_q <= dcnt_q + 5'd1;
			if (dcnt_q == 5'(NW - 1)) begin
				dbusy_q <= 1'b0;
				mean_q <= dneg_q ?
					gsoa_pkg::DEVW'(-$signed({1'b0, dnum_q[NW-2:0], !dtrial[NW]}))
					: gsoa_pkg::DEVW'({dnum_q[NW-2:0], !dtrial[NW]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dneg_q <= sum_q[NW-1];
			dnum_q <= sum_q[NW-1] ? NW'(-sum_q) : sum_q;
			drem_q <= '0;
		end else if (dbusy_q) begin
			dnum_q <= {dnum_q[NW-2:0], !dtrial[NW]};
			drem_q <= dtrial[NW] ? {drem_q[NW-2:0], dnum_q[NW-1]} : dtrial[NW-1:0];
		end
	end

	assign stat = '{cordic_done: !busy_q && !cmd.start,
		div_done: !dbusy_q && !cmd.div_start};

	logic signed [gsoa_pkg::DEVW-1:0] lim;
	assign lim = gsoa_pkg::DEVW'({2'b0, clamp_limit});
	always_comb begin
		if (mean_q > lim)
			offset_estimate = 16'(lim);
		else if (mean_q < -lim)
			offset_estimate = 16'(-lim);
		else
			offset_estimate = 16'(mean_q);
	end
	assign estimate_valid = count_q != '0;
endmodule

/* rtl/gsoa_ctrl.sv */
// Controller state machine: input/output transfers and sequencing of the datapath.
// Depends on gsoa_pkg; drives gsoa_datapath through cmd_t.
module gsoa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input logic taken,
	input gsoa_pkg::stat_t stat,
	output logic load,
	output gsoa_pkg::cmd_t cmd,
	output logic out_load
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GATE = 3'd1;
	localparam logic [2:0] S_CORDIC = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_DIV = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;
	localparam logic [2:0] S_DSTART = 3'd6;

	logic [2:0] state_q;

	assign in_stall = state_q != S_IDLE;
	assign load = in_valid && state_q == S_IDLE;
	assign out_load = state_q == S_OUT && (!out_valid || !out_stall);

	always_comb begin
		cmd = '0;
		cmd.start = state_q == S_GATE && taken;
		cmd.commit = state_q == S_COMMIT;
		cmd.div_start = state_q == S_DSTART;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			if (out_load)
				out_valid <= 1'b1;
			case (state_q)
				S_IDLE: if (load) state_q <= S_GATE;
				S_GATE: state_q <= taken ? S_CORDIC : S_OUT;
				S_CORDIC: if (stat.cordic_done) state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_DSTART;
				S_DSTART: state_q <= S_DIV;
				S_DIV: if (stat.div_done) state_q <= S_OUT;
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/gated_steering_offset_average.sv */
// Top level of the gated steering offset average block.
// Depends on gsoa_pkg, gsoa_ctrl and gsoa_datapath.
// One item at a time. An item that fails the gate goes from the input transfer through
// the gate and output states into the output register; a taken item also passes the
// CORDIC, min(ATAN_ITERATIONS, 24) steps at one step per cycle, the ring update and
// the 27-step restoring divider. The result sits in an output register; the next
// input can be transferred the cycle after it has been loaded.
module gated_steering_offset_average #(
	parameter int MAX_WINDOW = gsoa_pkg::MAX_WINDOW_DEF,
	parameter int ATAN_ITERATIONS = gsoa_pkg::ATAN_ITER_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [15:0] speed,
	input logic signed [15:0] yaw_rate,
	input logic signed [15:0] wheel_angle,
	output logic out_valid,
	input logic out_stall,
	output logic signed [15:0] offset_estimate,
	output logic estimate_valid,
	output logic sample_taken,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);
	logic [10:0] window_q;
	logic [14:0] speed_th_q, angle_th_q, limit_q;
	logic [11:0] wheelbase_q;
	logic load, out_load, taken;
	logic signed [15:0] est;
	logic est_valid;
	gsoa_pkg::cmd_t cmd;
	gsoa_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= gsoa_pkg::WINDOW_RST;
			speed_th_q <= gsoa_pkg::SPEED_TH_RST;
			angle_th_q <= gsoa_pkg::ANGLE_TH_RST;
			limit_q <= gsoa_pkg::LIMIT_RST;
			wheelbase_q <= gsoa_pkg::WHEELBASE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				gsoa_pkg::REG_WINDOW: window_q <= cfg_data[10:0];
				gsoa_pkg::REG_SPEED_TH: speed_th_q <= cfg_data[14:0];
				gsoa_pkg::REG_ANGLE_TH: angle_th_q <= cfg_data[14:0];
				gsoa_pkg::REG_LIMIT: limit_q <= cfg_data[14:0];
				gsoa_pkg::REG_WHEELBASE: wheelbase_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	gsoa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .taken(taken), .stat(stat),
		.load(load), .cmd(cmd), .out_load(out_load)
	);

	gsoa_datapath #(.MAX_WINDOW(MAX_WINDOW), .ATAN_ITERATIONS(ATAN_ITERATIONS)) u_dp (
		.clk(clk), .arst_n(arst_n), .load(load), .speed(speed), .yaw_rate(yaw_rate),
		.wheel_angle(wheel_angle), .window_length(window_q),
		.speed_threshold(speed_th_q), .angle_threshold(angle_th_q),
		.clamp_limit(limit_q), .wheelbase_length(wheelbase_q), .cmd(cmd),
		.stat(stat), .taken(taken), .offset_estimate(est),
		.estimate_valid(est_valid)
	);

	always_ff @(posedge clk) begin
		if (out_load) begin
			offset_estimate <= est;
			estimate_valid <= est_valid;
			sample_taken <= taken;
		end
	end
endmodule

/* rtl/gsoa_checker.sv */
// Port-level checker for gated_steering_offset_average, bound to the top level.
// Depends only on the top-level ports.
module gsoa_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [15:0] offset_estimate,
	input logic estimate_valid,
	input logic sample_taken
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(offset_estimate))
		else $error("result changed while stalled");
	a_taken_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_taken |-> estimate_valid)
		else $error("sample taken without valid estimate");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !estimate_valid |-> offset_estimate == 16'sd0)
		else $error("nonzero estimate before any sample");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer during work");
endmodule

bind gated_steering_offset_average gsoa_checker u_gsoa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .offset_estimate(offset_estimate),
	.estimate_valid(estimate_valid), .sample_taken(sample_taken)
);
